// File: hdl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, muted while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/c2p_pkg.sv
package c2p_pkg;

  // Fraction bits added below the input LSB in the rotation datapath.
  localparam int GUARD_BITS = 16;

  // Angle accumulator: 32 bits, pi = 2^31.
  localparam int ANGLE_BITS = 32;
  localparam logic [ANGLE_BITS-1:0] Z_PI = 32'h8000_0000;

  // Limit inverse CORDIC gain, Q0.32.
  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;

  // Rounding constant for dropping the guard bits.
  localparam logic [64:0] MAG_HALF = 65'd1 << (GUARD_BITS - 1);

  // atan(2^-i) in accumulator units, rounded to nearest.
  localparam logic [31:0] ATAN_UNITS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Forward control carried alongside each pipeline stage.
  typedef struct packed {
    logic valid;
    logic zero;
  } c2p_ctl_t;

endpackage

// File: hdl/c2p_if.sv
// Request channel: one cartesian point.
interface c2p_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] x_coord;
  logic signed [DATA_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// Result channel: one polar point.
interface c2p_out_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic        [DATA_WIDTH-1:0] magnitude;
  logic signed [DATA_WIDTH-1:0] angle;
  logic                         zero_input;

  modport source (output valid, output magnitude, output angle, output zero_input,
                  input ready);
  modport sink   (input valid, input magnitude, input angle, input zero_input,
                  output ready);
endinterface

// File: hdl/c2p_prerotate.sv
// Stage 0: fold the left half plane onto the right, scale in guard bits.
module c2p_prerotate #(
  parameter int DATA_WIDTH = 16,
  parameter int XW         = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  c2p_in_if.sink                point,
  output c2p_pkg::c2p_ctl_t     ctl,
  output logic signed [XW-1:0]  x,
  output logic signed [XW-1:0]  y,
  output logic [31:0]           z,
  input  logic                  ready_dn
);

  localparam int PAD = XW - DATA_WIDTH - 1 - c2p_pkg::GUARD_BITS;

  logic                       neg;
  logic signed [DATA_WIDTH:0] xe;
  logic signed [DATA_WIDTH:0] ye;
  logic signed [DATA_WIDTH:0] xa;
  logic signed [DATA_WIDTH:0] ya;
  logic signed [XW-1:0]       x_next;
  logic signed [XW-1:0]       y_next;
  logic [31:0]                z_next;
  logic                       zero_next;

  always_comb begin
    neg       = point.x_coord[DATA_WIDTH-1];
    xe        = {point.x_coord[DATA_WIDTH-1], point.x_coord};
    ye        = {point.y_coord[DATA_WIDTH-1], point.y_coord};
    xa        = neg ? -xe : xe;
    ya        = neg ? -ye : ye;
    x_next    = {{PAD{xa[DATA_WIDTH]}}, xa, {c2p_pkg::GUARD_BITS{1'b0}}};
    y_next    = {{PAD{ya[DATA_WIDTH]}}, ya, {c2p_pkg::GUARD_BITS{1'b0}}};
    z_next    = neg ? c2p_pkg::Z_PI : '0;
    zero_next = (point.x_coord == '0) && (point.y_coord == '0);
  end

  assign point.ready = !ctl.valid || ready_dn;

  // valid is reset, the payload is not
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else if (point.ready) begin
      ctl.valid <= point.valid;
    end
    if (point.ready && point.valid) begin
      ctl.zero <= zero_next;
      x        <= x_next;
      y        <= y_next;
      z        <= z_next;
    end
  end

endmodule

// File: hdl/c2p_stage.sv
// One CORDIC vectoring micro-rotation, registered.
module c2p_stage #(
  parameter int XW    = 35,
  parameter int SHIFT = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  c2p_pkg::c2p_ctl_t     ctl_in,
  input  logic signed [XW-1:0]  x_in,
  input  logic signed [XW-1:0]  y_in,
  input  logic [31:0]           z_in,
  output logic                  ready_up,
  output c2p_pkg::c2p_ctl_t     ctl_out,
  output logic signed [XW-1:0]  x_out,
  output logic signed [XW-1:0]  y_out,
  output logic [31:0]           z_out,
  input  logic                  ready_dn
);

  localparam logic [31:0] STEP = c2p_pkg::ATAN_UNITS[SHIFT];

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] x_next;
  logic signed [XW-1:0] y_next;
  logic [31:0]          z_next;

  always_comb begin
    xs = x_in >>> SHIFT;
    ys = y_in >>> SHIFT;
    // y == 0 rotates as positive
    if (!y_in[XW-1]) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + STEP;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - STEP;
    end
  end

  assign ready_up = !ctl_out.valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (ready_up) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (ready_up && ctl_in.valid) begin
      ctl_out.zero <= ctl_in.zero;
      x_out        <= x_next;
      y_out        <= y_next;
      z_out        <= z_next;
    end
  end

endmodule

// File: hdl/c2p_gain.sv
// Gain compensation and output rounding: three registered stages.
//   g1: two 32x32 partial products of x and the inverse gain
//   g2: combine partials, keep floor(x * gain / 2^32)
//   g3: round off guard bits, saturate, round angle, output register
module c2p_gain #(
  parameter int DATA_WIDTH = 16,
  parameter int XW         = 35
) (
  input  logic                  clk,
  input  logic                  rst,
  input  c2p_pkg::c2p_ctl_t     ctl_in,
  input  logic signed [XW-1:0]  x_in,
  input  logic [31:0]           z_in,
  output logic                  ready_up,
  c2p_out_if.source             polar
);

  localparam int MW = 65 - c2p_pkg::GUARD_BITS;

  // g1
  c2p_pkg::c2p_ctl_t ctl1;
  logic [63:0]       p_lo;
  logic [63:0]       p_hi;
  logic [31:0]       z1;
  logic [63:0]       xu;
  logic              rdy1;
  // g2
  c2p_pkg::c2p_ctl_t ctl2;
  logic [63:0]       prod;
  logic [31:0]       z2;
  logic              rdy2;
  // g3
  logic              rdy3;
  logic [64:0]       mag_sum;
  logic [MW-1:0]     mag_wide;
  logic [DATA_WIDTH-1:0] mag_next;
  logic [DATA_WIDTH-1:0] ang_next;

  assign rdy3     = !polar.valid || polar.ready;
  assign rdy2     = !ctl2.valid || rdy3;
  assign rdy1     = !ctl1.valid || rdy2;
  assign ready_up = rdy1;

  // negative x cannot occur after vectoring, clamp anyway
  assign xu = x_in[XW-1] ? '0 : 64'($unsigned(x_in));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid  <= 1'b0;
      ctl2.valid  <= 1'b0;
      polar.valid <= 1'b0;
    end else begin
      if (rdy1) ctl1.valid  <= ctl_in.valid;
      if (rdy2) ctl2.valid  <= ctl1.valid;
      if (rdy3) polar.valid <= ctl2.valid;
    end
    if (rdy1 && ctl_in.valid) begin
      ctl1.zero <= ctl_in.zero;
      z1        <= z_in;
      p_lo      <= 64'(xu[31:0]) * 64'(c2p_pkg::INV_GAIN);
      p_hi      <= 64'(xu[63:32]) * 64'(c2p_pkg::INV_GAIN);
    end
    if (rdy2 && ctl1.valid) begin
      ctl2.zero <= ctl1.zero;
      z2        <= z1;
      prod      <= p_hi + {32'd0, p_lo[63:32]};
    end
  end

  always_comb begin
    mag_sum  = {1'b0, prod} + c2p_pkg::MAG_HALF;
    mag_wide = mag_sum[64:c2p_pkg::GUARD_BITS];
    if (|mag_wide[MW-1:DATA_WIDTH]) begin
      mag_next = '1;
    end else begin
      mag_next = mag_wide[DATA_WIDTH-1:0];
    end
  end

  generate
    if (DATA_WIDTH < 32) begin : g_ang_round
      localparam int S = 32 - DATA_WIDTH;
      logic [32:0] za;
      assign za       = {1'b0, z2} + (33'd1 << (S - 1));
      assign ang_next = za[31:S];
    end else begin : g_ang_full
      assign ang_next = z2[DATA_WIDTH-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rdy3 && ctl2.valid) begin
      polar.zero_input <= ctl2.zero;
      polar.magnitude  <= ctl2.zero ? '0 : mag_next;
      polar.angle      <= ctl2.zero ? '0 : $signed(ang_next);
    end
  end

endmodule

// File: hdl/cartesian_to_polar.sv
// Cartesian to polar conversion by CORDIC vectoring. Each request carries a
// signed point (x_coord, y_coord); the result gives its magnitude on the
// same scale, compensated for CORDIC gain and rounded, its four-quadrant
// angle in binary angle units (2^(DATA_WIDTH-1) units = pi, pi itself wraps
// to the most negative code), and zero_input, set for the origin, where
// magnitude and angle are 0. Fully pipelined: a new request is taken every
// cycle unless a stalled result sink has filled the stages, and each passes
// one fold stage, one stage per micro-rotation and three gain and rounding
// stages from acceptance to result. Every stage has its own valid bit and a
// ready term, so empty stages fill while a result waits at the output register.
`include "assert_macros.svh"

module cartesian_to_polar #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic       clk,
  input  logic       rst,
  c2p_in_if.sink     point,
  c2p_out_if.source  polar
);

  // Rotation datapath: input, guard bits, sign and growth headroom.
  localparam int XW = DATA_WIDTH + c2p_pkg::GUARD_BITS + 3;

  // Index k is the output of the register holding pipeline slot k:
  // 0 is the fold stage, k > 0 follows micro-rotation k - 1.
  c2p_pkg::c2p_ctl_t    sctl   [ITERATIONS+1];
  logic signed [XW-1:0] sx     [ITERATIONS+1];
  logic signed [XW-1:0] sy     [ITERATIONS+1];
  logic [31:0]          sz     [ITERATIONS+1];
  // ready offered to slot k by whatever consumes it
  logic                 dn_rdy [ITERATIONS+1];

  // Fold x < 0 into the right half plane; the angle starts at pi there.
  c2p_prerotate #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_prerotate (
    .clk      (clk),
    .rst      (rst),
    .point    (point),
    .ctl      (sctl[0]),
    .x        (sx[0]),
    .y        (sy[0]),
    .z        (sz[0]),
    .ready_dn (dn_rdy[0])
  );

  // One registered micro-rotation per iteration, shift equal to its index.
  generate
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
      c2p_stage #(
        .XW    (XW),
        .SHIFT (i)
      ) u_stage (
        .clk      (clk),
        .rst      (rst),
        .ctl_in   (sctl[i]),
        .x_in     (sx[i]),
        .y_in     (sy[i]),
        .z_in     (sz[i]),
        .ready_up (dn_rdy[i]),
        .ctl_out  (sctl[i+1]),
        .x_out    (sx[i+1]),
        .y_out    (sy[i+1]),
        .z_out    (sz[i+1]),
        .ready_dn (dn_rdy[i+1])
      );
    end
  endgenerate

  // Final y is residue only; x goes on to gain compensation.
  c2p_gain #(
    .DATA_WIDTH (DATA_WIDTH),
    .XW         (XW)
  ) u_gain (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (sctl[ITERATIONS]),
    .x_in     (sx[ITERATIONS]),
    .z_in     (sz[ITERATIONS]),
    .ready_up (dn_rdy[ITERATIONS]),
    .polar    (polar)
  );

  // Origin results are forced to zero magnitude and angle.
  `ASSERT_CLK(a_zero_result, polar.valid && polar.zero_input |-> polar.magnitude == '0 && polar.angle == '0, "origin result not cleared")
  // A ready sink lets every stage advance, so requests are never refused while it is ready.
  `ASSERT_CLK(a_ready_chain, polar.ready |-> point.ready, "ready chain broken")
  // Reset empties the pipeline.
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !polar.valid, "result valid after reset")

endmodule
